// ===== rtl/tbb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the tile board bus.
package tbb_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_TILE  = 2'd3;

  // ROM access kinds reported on a bus read.
  localparam logic [1:0] ROM_NONE   = 2'd0;
  localparam logic [1:0] ROM_BANKED = 2'd1;
  localparam logic [1:0] ROM_FIXED  = 2'd2;

  // Bus map.
  localparam logic [15:0] ADDR_PAGE      = 16'h0000;
  localparam logic [15:0] ADDR_BANK      = 16'hC000;
  localparam logic [15:0] ADDR_VBL       = 16'hC101;
  localparam logic [15:0] ADDR_STATUS    = 16'hC103;
  localparam logic [15:0] SCREEN_BASE    = 16'h8000;
  localparam logic [15:0] FIXED_ROM_BASE = 16'hE000;

  // Palette window inside a screen page.
  localparam logic [12:0] PAL_FIRST = 13'd103;
  localparam logic [12:0] PAL_LAST  = 13'd118;

  // Widest memory indexes over the legal size range.
  localparam int SCR_IDX_W   = 13;
  localparam int WORK_IDX_W  = 12;
  localparam int TILE_WORD_W = 17;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        uart_irq_pending;
    logic [10:0] tile_number;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  rom_read;
    logic [16:0] rom_address;
    logic        irq_raise;
    logic        palette_valid;
    logic [3:0]  palette_index;
    logic [7:0]  palette_red;
    logic [7:0]  palette_green;
    logic [7:0]  palette_blue;
    logic [12:0] tile_code;
    logic        tile_flip_x;
    logic        tile_flip_y;
  } rsp_t;

  // Screen RAM port: one word index, a byte lane write enable for each half.
  typedef struct packed {
    logic                 rd;
    logic                 wr_even;
    logic                 wr_odd;
    logic [SCR_IDX_W-1:0] idx;
    logic [7:0]           wdata;
  } scr_req_t;

  typedef struct packed {
    logic                  rd;
    logic                  wr;
    logic [WORK_IDX_W-1:0] idx;
    logic [7:0]            wdata;
  } work_req_t;

  // A two-bit color field times 85 is the field repeated four times.
  function automatic logic [7:0] level2(input logic [1:0] f);
    return {4{f}};
  endfunction

endpackage

// ===== rtl/tbb_screen_ram.sv =====
`timescale 1ns / 1ps
// Two-page screen RAM, split into even and odd byte lanes, with a clearing sweep after reset.
module tbb_screen_ram
  import tbb_pkg::*;
#(
  parameter int SCREEN_BYTES = 4480
) (
  input  logic       clk,
  input  logic       rst,
  input  scr_req_t   req,
  output logic [7:0] rdata_even,
  output logic [7:0] rdata_odd,
  output logic       busy
);

  localparam int WORDS = (SCREEN_BYTES + 1) / 2;
  localparam int DEPTH = 2 * WORDS;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]    mem_even [DEPTH];
  logic [7:0]    mem_odd  [DEPTH];
  logic          clearing;
  logic [AW-1:0] clr_idx;
  logic [AW-1:0] idx;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          we_even;
  logic          we_odd;

  assign idx     = req.idx[AW-1:0];
  assign waddr   = clearing ? clr_idx : idx;
  assign wdata   = clearing ? 8'd0 : req.wdata;
  assign we_even = clearing || req.wr_even;
  assign we_odd  = clearing || req.wr_odd;
  assign busy    = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we_even) begin
      mem_even[waddr] <= wdata;
    end
    if (req.rd) begin
      rdata_even <= mem_even[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (we_odd) begin
      mem_odd[waddr] <= wdata;
    end
    if (req.rd) begin
      rdata_odd <= mem_odd[idx];
    end
  end

endmodule

// ===== rtl/tbb_work_ram.sv =====
`timescale 1ns / 1ps
// Work RAM of the processor bus, one byte wide.
module tbb_work_ram
  import tbb_pkg::*;
#(
  parameter int WORK_BYTES = 3712
) (
  input  logic       clk,
  input  work_req_t  req,
  output logic [7:0] rdata
);

  localparam int AW = $clog2(WORK_BYTES);

  logic [7:0]    mem [WORK_BYTES];
  logic [AW-1:0] idx;

  assign idx = req.idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[idx] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[idx];
    end
  end

endmodule

// ===== rtl/tbb_tile_div.sv =====
`timescale 1ns / 1ps
// Tile number to screen word index: row and column by reciprocal multiply with one correction.
module tbb_tile_div
  import tbb_pkg::*;
#(
  parameter int COLUMNS = 50
) (
  input  logic                   clk,
  input  logic [10:0]            tile_number,
  output logic [TILE_WORD_W-1:0] word
);

  localparam int SHIFT = 17;
  localparam int RECIP = (1 << SHIFT) / COLUMNS;
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = CW + 1;

  logic [10:0]   idx_d;
  logic [28:0]   prod;
  logic [10:0]   q_raw;
  logic [17:0]   qc;
  logic [10:0]   r_wide;
  logic [10:0]   q_est;
  logic [RW-1:0] r_est;
  logic [10:0]   q_fix;
  logic [RW-1:0] r_fix;

  // The truncated reciprocal never overestimates and falls short by one at most.
  always_comb begin
    q_raw  = prod[27:17];
    qc     = 18'(q_raw) * 18'(COLUMNS);
    r_wide = idx_d - qc[10:0];
  end

  always_ff @(posedge clk) begin
    idx_d <= tile_number;
    prod  <= 29'(tile_number) * 29'(RECIP);
    q_est <= q_raw;
    r_est <= RW'(r_wide);
  end

  always_comb begin
    q_fix = q_est;
    r_fix = r_est;
    if (r_est >= RW'(COLUMNS)) begin
      q_fix = q_est + 11'd1;
      r_fix = r_est - RW'(COLUMNS);
    end
    // A screen row is 128 bytes, so 64 words.
    word = {q_fix, 6'(r_fix)};
  end

endmodule

// ===== rtl/tile_board_bus_and_fetch_core.sv =====
`timescale 1ns / 1ps
// Top level of the tile board bus: decode, registers, sequencing and the result register.
//
//   channel  valid      stall      payload  beat
//   request  req_valid  req_stall  req      bus read, bus write, vblank tick or tile fetch
//   result   rsp_valid  rsp_stall  rsp      one result beat per request beat
//
// A bus read, bus write or tick goes from accept through the access and response states back
// to idle; a tile fetch first passes the multiply and divide states of the tile divider. Memory
// reads go through the registered screen and work RAM ports, with data in the cycle after access.
// After reset the screen RAM is swept to zero, one word per lane a cycle; req_stall stays high
// until the sweep ends.
// A result beat waits in the result register while rsp_stall is high; the next request is
// accepted meanwhile and is held in the response state until the register frees.
module tile_board_bus_and_fetch_core
  import tbb_pkg::*;
#(
  parameter int SCREEN_BYTES = 4480,
  parameter int WORK_BYTES   = 3712,
  parameter int TILE_COLUMNS = 50
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int          SCR_WORDS    = (SCREEN_BYTES + 1) / 2;
  localparam int          SCR_LO_WORDS = SCREEN_BYTES / 2;
  localparam logic [16:0] WORK_BASE    = 17'(32768 + SCREEN_BYTES);
  localparam logic [16:0] WORK_END     = 17'(32768 + SCREEN_BYTES + WORK_BYTES);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_ACCESS = 5'b01000,
    ST_RESP   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  req_t   item;
  rsp_t   pend;
  rsp_t   pend_next;
  rsp_t   rsp_next;

  logic [1:0] page_select;
  logic [7:0] vbl_control;
  logic       vbl_flag;
  logic [1:0] rom_bank;

  logic sel_scr;
  logic sel_odd;
  logic sel_work;
  logic sel_tile;
  logic tile_hi_ok;
  logic tile_lo_ok;

  logic                   accept;
  logic                   rsp_load;
  logic                   scr_busy;
  logic [7:0]             scr_even;
  logic [7:0]             scr_odd;
  logic [7:0]             work_rdata;
  logic [TILE_WORD_W-1:0] tile_word;
  scr_req_t               scr_req;
  work_req_t              work_req;

  logic [16:0]          a17;
  logic                 is_banked;
  logic                 is_fixed;
  logic                 is_scr;
  logic                 is_work;
  logic                 is_pal;
  logic [12:0]          scr_off;
  logic                 page;
  logic [SCR_IDX_W-1:0] word_sel;
  logic                 in_access;
  logic                 op_read;
  logic                 op_write;
  logic                 op_tile;
  logic [15:0]          tile_bytes;

  tbb_screen_ram #(
    .SCREEN_BYTES(SCREEN_BYTES)
  ) u_screen (
    .clk       (clk),
    .rst       (rst),
    .req       (scr_req),
    .rdata_even(scr_even),
    .rdata_odd (scr_odd),
    .busy      (scr_busy)
  );

  tbb_work_ram #(
    .WORK_BYTES(WORK_BYTES)
  ) u_work (
    .clk  (clk),
    .req  (work_req),
    .rdata(work_rdata)
  );

  tbb_tile_div #(
    .COLUMNS(TILE_COLUMNS)
  ) u_div (
    .clk        (clk),
    .tile_number(item.tile_number),
    .word       (tile_word)
  );

  assign req_stall = (state != ST_IDLE) || scr_busy;
  assign accept    = req_valid && !req_stall;
  assign rsp_load  = (state == ST_RESP) && (!rsp_valid || !rsp_stall);

  // Address decode of the held item.
  always_comb begin
    in_access = (state == ST_ACCESS);
    op_read   = (item.operation == OP_READ);
    op_write  = (item.operation == OP_WRITE);
    op_tile   = (item.operation == OP_TILE);
    a17       = {1'b0, item.address};
    is_banked = !item.address[15];
    is_fixed  = item.address >= FIXED_ROM_BASE;
    is_scr    = item.address[15] && (a17 < WORK_BASE);
    is_work   = (a17 >= WORK_BASE) && (a17 < WORK_END);
    scr_off   = 13'(item.address - SCREEN_BASE);
    is_pal    = (scr_off >= PAL_FIRST) && (scr_off <= PAL_LAST);
    page      = op_tile ? page_select[1] : page_select[0];
    word_sel  = op_tile ? SCR_IDX_W'(tile_word) : SCR_IDX_W'(scr_off[12:1]);
  end

  always_comb begin
    scr_req.rd      = in_access && ((op_read && is_scr) || op_tile);
    scr_req.wr_even = in_access && op_write && is_scr && !scr_off[0];
    scr_req.wr_odd  = in_access && op_write && is_scr && scr_off[0];
    scr_req.idx     = word_sel + (page ? SCR_IDX_W'(SCR_WORDS) : SCR_IDX_W'(0));
    scr_req.wdata   = item.write_data;

    work_req.rd    = in_access && op_read && is_work;
    work_req.wr    = in_access && op_write && is_work;
    work_req.idx   = WORK_IDX_W'(a17 - WORK_BASE);
    work_req.wdata = item.write_data;
  end

  // Everything of the result that does not come from a memory.
  always_comb begin
    pend_next = '0;
    unique case (item.operation)
      OP_READ: begin
        priority if (is_banked) begin
          pend_next.rom_read    = ROM_BANKED;
          pend_next.rom_address = {rom_bank, item.address[14:0]};
        end else if (is_fixed) begin
          pend_next.rom_read    = ROM_FIXED;
          pend_next.rom_address = a17;
        end else if (item.address == ADDR_VBL) begin
          pend_next.read_data = vbl_control;
        end else if (item.address == ADDR_STATUS) begin
          pend_next.read_data = {4'b0000, item.uart_irq_pending, 1'b0, vbl_flag, 1'b0};
        end
      end
      OP_WRITE: begin
        if (is_scr && is_pal) begin
          pend_next.palette_valid = 1'b1;
          pend_next.palette_index = 4'(scr_off - PAL_FIRST);
          pend_next.palette_red   = level2(item.write_data[4:3]);
          pend_next.palette_green = level2(item.write_data[2:1]);
          pend_next.palette_blue  = {8{item.write_data[0]}};
        end
      end
      OP_TICK: begin
        pend_next.irq_raise = vbl_control[0];
      end
      OP_TILE: begin
      end
    endcase
  end

  always_comb begin
    unique case (state)
      ST_IDLE: begin
        state_next = ST_IDLE;
        if (accept) begin
          state_next = (req.operation == OP_TILE) ? ST_MUL : ST_ACCESS;
        end
      end
      ST_MUL:    state_next = ST_DIV;
      ST_DIV:    state_next = ST_ACCESS;
      ST_ACCESS: state_next = ST_RESP;
      ST_RESP:   state_next = rsp_load ? ST_IDLE : ST_RESP;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item <= '0;
    end else if (accept) begin
      item <= req;
    end
  end

  // Register side effects land in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_select <= '0;
      vbl_control <= '0;
      vbl_flag    <= 1'b0;
      rom_bank    <= '0;
    end else if (in_access) begin
      if (op_write && item.address == ADDR_PAGE) begin
        page_select <= item.write_data[1:0];
      end
      if (op_write && item.address == ADDR_BANK) begin
        rom_bank <= item.write_data[1:0];
      end
      if (op_write && item.address == ADDR_VBL) begin
        vbl_control <= item.write_data;
      end
      if (op_read && item.address == ADDR_VBL) begin
        vbl_flag <= 1'b0;
      end
      if (item.operation == OP_TICK && vbl_control[0]) begin
        vbl_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_access) begin
      pend       <= pend_next;
      sel_scr    <= op_read && is_scr;
      sel_odd    <= scr_off[0];
      sel_work   <= op_read && is_work;
      sel_tile   <= op_tile;
      tile_hi_ok <= tile_word < TILE_WORD_W'(SCR_WORDS);
      tile_lo_ok <= tile_word < TILE_WORD_W'(SCR_LO_WORDS);
    end
  end

  // Merge the memory data into the result; tile bytes past the page read as zero.
  always_comb begin
    rsp_next   = pend;
    tile_bytes = {tile_hi_ok ? scr_even : 8'd0, tile_lo_ok ? scr_odd : 8'd0};
    if (sel_scr) begin
      rsp_next.read_data = sel_odd ? scr_odd : scr_even;
    end else if (sel_work) begin
      rsp_next.read_data = work_rdata;
    end
    if (sel_tile) begin
      rsp_next.tile_code   = tile_bytes[12:0];
      rsp_next.tile_flip_x = tile_bytes[13];
      rsp_next.tile_flip_y = tile_bytes[14];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_rsp_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_RESP))
    else $error("result beat appeared without passing the response state");

  a_resp_drains: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP) && (!rsp_valid || !rsp_stall) |=> rsp_valid && (state == ST_IDLE))
    else $error("free result register did not take the response");

  a_tile_through_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACCESS) && (item.operation == OP_TILE) |-> $past(state == ST_DIV))
    else $error("tile fetch reached the access cycle before the divider settled");

  a_irq_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.irq_raise |->
      (rsp.rom_read == ROM_NONE) && !rsp.palette_valid && (rsp.read_data == 8'd0))
    else $error("interrupt beat carries bus or palette data");
`endif

endmodule
